/* sv/r565y_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r565y_pkg
// Shared types and constants of the RGB565 to YUYV 4:2:2 packer.
// ----------------------------------------------------------------------------
package r565y_pkg;

    localparam int PIXEL_W = 16;
    localparam int BYTE_W  = 8;
    localparam int SUM_W   = 18;

    // Depth of the result queue; two slots must be free before a pair is written.
    localparam int QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] RED_MASK   = 8'hF8;
    localparam logic [BYTE_W-1:0] GREEN_MASK = 8'hFC;
    localparam logic [BYTE_W-1:0] BLUE_MASK  = 8'hF8;

    localparam logic [BYTE_W-1:0] LUMA_OFFSET   = 8'd16;
    localparam logic [BYTE_W-1:0] CHROMA_OFFSET = 8'd128;

    typedef struct packed {
        logic [BYTE_W-1:0] luma;
        logic [BYTE_W-1:0] chroma;
        logic              pair_end;
        logic              frame_end;
    } t_result;

endpackage

/* sv/rgb565_to_yuyv422_packer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_to_yuyv422_packer_unit
// Converts RGB565 pixels to BT.601 studio-range YUYV 4:2:2 byte pairs.
// ----------------------------------------------------------------------------
// The block accepts one RGB565 pixel per clock while o_ready is high. Each
// pixel is captured in an input register, converted combinationally to Y,
// Cb and Cr by constant multiplies, and either held (first pixel of a pair)
// or combined with the held pixel; the pair then writes (Y0, U) and (Y1, V)
// into a four-entry result queue that drives one result per clock while
// i_ready is high. A pixel is taken whenever the queue holds two entries or
// fewer, so a continuous stream runs at one pixel per clock if i_ready stays
// high. A final pixel without a partner is paired with itself and still
// yields two results, the second flagged as frame end.
// ----------------------------------------------------------------------------
module rgb565_to_yuyv422_packer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [r565y_pkg::PIXEL_W-1:0]  i_pixel,
    input  logic                           i_last_pixel,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [r565y_pkg::BYTE_W-1:0]   o_luma,
    output logic [r565y_pkg::BYTE_W-1:0]   o_chroma,
    output logic                           o_pair_end,
    output logic                           o_frame_end
);
    import r565y_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Input register.
    logic                r_s1_valid;
    logic [PIXEL_W-1:0]  r_s1_pixel;
    logic                r_s1_last;

    // Pairing state.
    logic                r_have_first;
    logic [BYTE_W-1:0]   r_held_luma;
    logic [BYTE_W-1:0]   r_held_cb;
    logic [BYTE_W-1:0]   r_held_cr;

    // Result queue.
    t_result             r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;

    logic                consume;
    logic                emit;
    logic                pop;
    logic [BYTE_W-1:0]   red;
    logic [BYTE_W-1:0]   green;
    logic [BYTE_W-1:0]   blue;
    logic signed [SUM_W-1:0] red_s;
    logic signed [SUM_W-1:0] green_s;
    logic signed [SUM_W-1:0] blue_s;
    logic signed [SUM_W-1:0] y_sum;
    logic signed [SUM_W-1:0] cb_sum;
    logic signed [SUM_W-1:0] cr_sum;
    logic [BYTE_W-1:0]   cur_luma;
    logic [BYTE_W-1:0]   cur_cb;
    logic [BYTE_W-1:0]   cur_cr;
    logic [BYTE_W-1:0]   first_luma;
    logic [BYTE_W-1:0]   first_cb;
    logic [BYTE_W-1:0]   first_cr;
    logic [BYTE_W:0]     cb_pair;
    logic [BYTE_W:0]     cr_pair;
    t_result             res_first;
    t_result             res_second;
    t_result             head;

    // Two free slots are required, so an emitting pixel never overruns the queue.
    assign consume = r_s1_valid && (r_count <= CNT_W'(QUEUE_DEPTH - 2));
    assign o_ready = !r_s1_valid || consume;
    assign emit    = consume && (r_have_first || r_s1_last);
    assign pop     = o_valid && i_ready;

    always_comb begin
        red     = r_s1_pixel[15:8] & RED_MASK;
        green   = r_s1_pixel[10:3] & GREEN_MASK;
        blue    = {r_s1_pixel[4:0], 3'b000} & BLUE_MASK;
        red_s   = $signed({{(SUM_W-BYTE_W){1'b0}}, red});
        green_s = $signed({{(SUM_W-BYTE_W){1'b0}}, green});
        blue_s  = $signed({{(SUM_W-BYTE_W){1'b0}}, blue});
        y_sum   = 18'sd66 * red_s + 18'sd129 * green_s + 18'sd25 * blue_s + 18'sd128;
        cb_sum  = 18'sd128 - 18'sd38 * red_s - 18'sd74 * green_s + 18'sd112 * blue_s;
        cr_sum  = 18'sd128 + 18'sd112 * red_s - 18'sd94 * green_s - 18'sd18 * blue_s;
        // The low byte of an arithmetic shift by eight is simply bits 15..8.
        cur_luma = y_sum[15:8] + LUMA_OFFSET;
        cur_cb   = cb_sum[15:8] + CHROMA_OFFSET;
        cur_cr   = cr_sum[15:8] + CHROMA_OFFSET;

        // A lone final pixel is paired with itself.
        if (r_have_first) begin
            first_luma = r_held_luma;
            first_cb   = r_held_cb;
            first_cr   = r_held_cr;
        end else begin
            first_luma = cur_luma;
            first_cb   = cur_cb;
            first_cr   = cur_cr;
        end
        cb_pair = {1'b0, first_cb} + {1'b0, cur_cb};
        cr_pair = {1'b0, first_cr} + {1'b0, cur_cr};

        res_first.luma       = first_luma;
        res_first.chroma     = cb_pair[BYTE_W:1];
        res_first.pair_end   = 1'b0;
        res_first.frame_end  = 1'b0;
        res_second.luma      = cur_luma;
        res_second.chroma    = cr_pair[BYTE_W:1];
        res_second.pair_end  = 1'b1;
        res_second.frame_end = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_s1_pixel <= i_pixel;
            r_s1_last  <= i_last_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_first <= 1'b0;
            r_held_luma  <= '0;
            r_held_cb    <= '0;
            r_held_cr    <= '0;
        end else if (consume) begin
            if (emit) begin
                r_have_first <= 1'b0;
            end else begin
                r_have_first <= 1'b1;
                r_held_luma  <= cur_luma;
                r_held_cb    <= cur_cb;
                r_held_cr    <= cur_cr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_queue[r_wr_ptr]              <= res_first;
            r_queue[r_wr_ptr + PTR_W'(1)]  <= res_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (emit) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(2);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + (emit ? CNT_W'(2) : CNT_W'(0)) - (pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    assign head        = r_queue[r_rd_ptr];
    assign o_valid     = (r_count != '0);
    assign o_luma      = head.luma;
    assign o_chroma    = head.chroma;
    assign o_pair_end  = head.pair_end;
    assign o_frame_end = head.frame_end;

endmodule
